[src/unique_fifo_queue_macros.svh]
// Assertion macros shared by the unique_fifo_queue checker.
// No dependencies; include by bare file name.
`ifndef UNIQUE_FIFO_QUEUE_MACROS_SVH
`define UNIQUE_FIFO_QUEUE_MACROS_SVH

// Clocked property, switched off while reset is asserted (active low).
`define UFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define UFQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ufq_pkg.sv]
// Shared types and constants for the unique_fifo_queue block.
// No dependencies; used by the cell, the top level and the checker.
package ufq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned VAL_W = 31;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = ((VAL_W + 7) / 8) * 8;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic shift;  // take the neighbor's value (remove)
    logic load;   // take the inserted value (this cell is the tail slot)
  } cell_ctrl_t;

endpackage

[src/ufq_cell.sv]
// One storage cell of the unique_fifo_queue chain: holds a value, shifts
// toward the head on remove, loads on insert, compares against the key.
// Depends on ufq_pkg.
module ufq_cell (
  input  logic                        clk_i,
  input  ufq_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        occupied_i,
  input  logic [ufq_pkg::VAL_W-1:0]   next_value_i,
  input  logic [ufq_pkg::VAL_W-1:0]   ins_value_i,
  output logic [ufq_pkg::VAL_W-1:0]   value_o,
  output logic                        match_o
);

  logic [ufq_pkg::VAL_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.shift) begin
      value_d = next_value_i;
    end else if (ctrl_i.load) begin
      value_d = ins_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign match_o = occupied_i && (value_q == ins_value_i);

endmodule

[src/unique_fifo_queue.sv]
// unique_fifo_queue: FIFO of 31-bit values that rejects duplicates; uses ufq_pkg, ufq_cell.
// The result of an accepted input transaction is registered and appears in the cycle after acceptance.
// Throughput: one transaction per cycle; all cells compare and shift in one step,
// and the input stalls only while a result waits on m_axis_tready.
// Reset: entry count and result valid clear at once; cell contents are not
// cleared and are never read before they are written.
module unique_fifo_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ufq_pkg::DATA_W-1:0]   s_axis_tdata,   // [30:0] value, rest zero
  input  logic                         s_axis_tuser,   // [0] command
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ufq_pkg::DATA_W-1:0]   m_axis_tdata,   // [30:0] result_value, rest zero
  output logic [1:0]                   m_axis_tuser    // [1:0] status
);

  localparam int unsigned N = ufq_pkg::DEPTH;

  // Queue occupancy; cell 0 holds the oldest entry.
  logic [ufq_pkg::CNT_W-1:0] count_q, count_d;

  // Result register decouples the output side from the queue.
  logic                        out_valid_q, out_valid_d;
  logic [ufq_pkg::VAL_W-1:0]   out_value_q, out_value_d;
  ufq_pkg::status_e            out_status_q, out_status_d;

  logic [ufq_pkg::VAL_W-1:0]   key;
  logic                        accept;
  logic                        is_insert;
  logic                        full;
  logic                        empty;
  logic                        dup;
  logic                        ins_ok;
  logic                        rem_ok;

  logic [N-1:0]                occupied;
  logic [N-1:0]                match;
  logic [ufq_pkg::VAL_W-1:0]   cell_value [N];
  ufq_pkg::cell_ctrl_t         cell_ctrl  [N];

  assign key       = s_axis_tdata[ufq_pkg::VAL_W-1:0];
  assign is_insert = (s_axis_tuser == ufq_pkg::CMD_INSERT);

  // Take a new transaction whenever the result slot is free or draining.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full   = (count_q == ufq_pkg::CNT_W'(N));
  assign empty  = (count_q == '0);
  assign dup    = |match;
  // Full wins over duplicate.
  assign ins_ok = is_insert && !full && !dup;
  assign rem_ok = !is_insert && !empty;

  // Build the chain of cells; each one hands its value to the one below.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [ufq_pkg::VAL_W-1:0] next_value;

    assign occupied[i]        = (ufq_pkg::CNT_W'(i) < count_q);
    assign cell_ctrl[i].shift = accept && rem_ok;
    // The tail slot is the first free cell.
    assign cell_ctrl[i].load  = accept && ins_ok && (count_q == ufq_pkg::CNT_W'(i));

    if (i == N - 1) begin : g_last
      // Nothing above the last cell: it holds its own value on a shift.
      assign next_value = cell_value[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end

    ufq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[i]),
      .occupied_i   (occupied[i]),
      .next_value_i (next_value),
      .ins_value_i  (key),
      .value_o      (cell_value[i]),
      .match_o      (match[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    // Drop the result once the downstream side takes it.
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (accept) begin
      out_valid_d = 1'b1;
      out_value_d = '0;
      if (is_insert) begin
        if (full) begin
          out_status_d = ufq_pkg::ST_FULL;
        end else if (dup) begin
          out_status_d = ufq_pkg::ST_DUP;
        end else begin
          out_status_d = ufq_pkg::ST_OK;
          out_value_d  = key;
          count_d      = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          out_status_d = ufq_pkg::ST_EMPTY;
        end else begin
          // Return the head; the chain shifts it out this cycle.
          out_status_d = ufq_pkg::ST_OK;
          out_value_d  = cell_value[0];
          count_d      = count_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ufq_pkg::DATA_W'(out_value_q);
  assign m_axis_tuser  = out_status_q;

endmodule

[src/ufq_checker.sv]
// Port-level checker for unique_fifo_queue, attached by bind.
// Depends on ufq_pkg and unique_fifo_queue_macros.svh.
`include "unique_fifo_queue_macros.svh"

module ufq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [ufq_pkg::DATA_W-1:0] s_axis_tdata,
  input logic                       s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [ufq_pkg::DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                 m_axis_tuser
);

  // Every accepted transaction shows its result on the next cycle.
  `UFQ_ASSERT(a_result_next, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid, "accepted transaction produced no result")

  // Input side stalls only behind a result that is not taken.
  `UFQ_ASSERT_ALWAYS(a_stall_cause, clk_i, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input stalled without output backpressure")

  // A refused or empty result carries zero data.
  `UFQ_ASSERT(a_zero_on_error, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tuser != ufq_pkg::ST_OK)) |-> (m_axis_tdata == '0), "nonzero data with error status")

  // A stalled result holds its payload.
  `UFQ_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind unique_fifo_queue ufq_checker u_ufq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_unique_fifo_queue.sv]
`timescale 1ns / 100ps
// Self-checking testbench for unique_fifo_queue: stream stimulus, shadow queue predictor,
// in-order result checker. Depends on ufq_pkg and the unique_fifo_queue RTL.
module tb_unique_fifo_queue;

  localparam int unsigned CLK_HALF_NS     = 6;
  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned IDLE_PCT        = 24;
  localparam int unsigned RANDOM_ITEMS    = 600;
  localparam int unsigned NO_IDLE_ITEMS   = 80;
  localparam int unsigned HOLD_OFF_ITEMS  = 40;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned SEGMENT_ITEMS   = 30;
  localparam int unsigned DRAIN_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned TIMEOUT_NS      = 5_000_000;

  typedef logic [ufq_pkg::VAL_W-1:0] value_t;

  // One result transaction as the block should produce it.
  typedef struct packed {
    value_t           value;
    ufq_pkg::status_e status;
  } queue_result_t;

  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [ufq_pkg::DATA_W-1:0]  s_axis_tdata  = '0;   // [30:0] value, rest zero
  logic                        s_axis_tuser  = 1'b0; // [0] command
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [ufq_pkg::DATA_W-1:0]  m_axis_tdata;         // [30:0] result_value, rest zero
  logic [1:0]                  m_axis_tuser;         // [1:0] status

  // Shadow copy of the stored values, oldest first, and the results still owed.
  value_t        shadow_entries[$];
  queue_result_t pending_results[$];

  int unsigned error_count      = 0;
  int unsigned tx_idle_pct      = IDLE_PCT;
  int unsigned rx_idle_pct      = IDLE_PCT;
  bit          hold_off_request = 1'b0;

  unique_fifo_queue u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Apply one queue operation to the shadow queue and return its result.
  // Full takes priority over duplicate; every stored entry is compared.
  function automatic queue_result_t predict_queue_op(ufq_pkg::cmd_e cmd, value_t value);
    queue_result_t res;
    bit            found;
    res.value  = '0;
    res.status = ufq_pkg::ST_OK;
    found      = 1'b0;
    if (cmd == ufq_pkg::CMD_INSERT) begin
      foreach (shadow_entries[i]) begin
        if (shadow_entries[i] == value) found = 1'b1;
      end
      if (shadow_entries.size() >= ufq_pkg::DEPTH) begin
        res.status = ufq_pkg::ST_FULL;
      end else if (found) begin
        res.status = ufq_pkg::ST_DUP;
      end else begin
        shadow_entries.push_back(value);
        res.value = value;
      end
    end else begin
      if (shadow_entries.size() == 0) begin
        res.status = ufq_pkg::ST_EMPTY;
      end else begin
        res.value = shadow_entries.pop_front();
      end
    end
    return res;
  endfunction

  // Pick a value: often from a small pool so duplicates are common, sometimes a
  // value already stored, an extreme, or a fully random 31-bit value.
  function automatic value_t pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) begin
      return value_t'($urandom_range(23));
    end else if (sel < 70 && shadow_entries.size() != 0) begin
      return shadow_entries[$urandom_range(shadow_entries.size() - 1)];
    end else if (sel < 80) begin
      case ($urandom_range(2))
        0:       return '0;
        1:       return '1;
        default: return value_t'(1) << $urandom_range(ufq_pkg::VAL_W - 1);
      endcase
    end
    return value_t'($urandom);
  endfunction

  // Send one transaction. Call at a falling edge; returns at a falling edge.
  // Drop tvalid only on idle cycles, so a back-to-back item keeps it high.
  task automatic send_item(ufq_pkg::cmd_e cmd, value_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(ufq_pkg::DATA_W - ufq_pkg::VAL_W){1'b0}}, value};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_queue_op(cmd, value));
    @(negedge clk_i);
  endtask

  // Random operation with the insert share given in percent.
  task automatic send_random_item(int unsigned insert_pct);
    if ($urandom_range(99) < insert_pct) begin
      send_item(ufq_pkg::CMD_INSERT, pick_value());
    end else begin
      // Value is ignored for remove; drive random bits anyway.
      send_item(ufq_pkg::CMD_REMOVE, value_t'($urandom));
    end
  endtask

  // Remove from empty, both value extremes, duplicate of the newest entry,
  // and removes that carry nonzero (ignored) value bits.
  task automatic test_empty_and_extremes();
    send_item(ufq_pkg::CMD_REMOVE, '1);
    send_item(ufq_pkg::CMD_INSERT, '0);
    send_item(ufq_pkg::CMD_INSERT, '1);
    send_item(ufq_pkg::CMD_INSERT, '0);
    send_item(ufq_pkg::CMD_INSERT, '1);
    send_item(ufq_pkg::CMD_REMOVE, '1);
    send_item(ufq_pkg::CMD_REMOVE, value_t'(32'h2AAA_AAAA));
    send_item(ufq_pkg::CMD_REMOVE, '0);
  endtask

  // Fill to DEPTH, then insert a new value and a stored value: both full.
  task automatic test_full_beats_duplicate();
    for (int unsigned i = 0; i < ufq_pkg::DEPTH; i++) begin
      send_item(ufq_pkg::CMD_INSERT, value_t'(32'h5555_5555 ^ i));
    end
    send_item(ufq_pkg::CMD_INSERT, value_t'(32'h1234_5678));
    send_item(ufq_pkg::CMD_INSERT, value_t'(32'h5555_5555));
  endtask

  // Random traffic in segments that lean to insert or to remove, so the
  // queue swings between empty and full.
  task automatic test_random_mix(int unsigned item_total);
    int unsigned insert_pct;
    insert_pct = 50;
    for (int unsigned i = 0; i < item_total; i++) begin
      if (i % SEGMENT_ITEMS == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      send_random_item(insert_pct);
    end
  endtask

  // Full-rate stretch: neither side idles.
  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_mix(NO_IDLE_ITEMS);
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
  endtask

  // Hold the output off for a long stretch while input keeps coming, so the
  // result register fills and the block stalls its input.
  task automatic test_output_hold_off();
    hold_off_request = 1'b1;
    for (int unsigned i = 0; i < HOLD_OFF_ITEMS; i++) begin
      send_random_item(70);
    end
  endtask

  // Receiver: idle at random, or hold tready low for a counted stretch.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Checker: compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_value %0h status %0d",
               m_axis_tdata[ufq_pkg::VAL_W-1:0], m_axis_tuser);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[ufq_pkg::VAL_W-1:0] !== want.value) begin
          $error("result_value mismatch: expected %0h, actual %0h",
                 want.value, m_axis_tdata[ufq_pkg::VAL_W-1:0]);
          error_count++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset once, run each test, drain, report.
  initial begin
    int unsigned waited;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_extremes();
    test_full_beats_duplicate();
    test_random_mix(RANDOM_ITEMS);
    test_full_rate();
    test_output_hold_off();

    // Release the input and wait for every owed result.
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("tb_unique_fifo_queue: clean");
    end else begin
      $display("tb_unique_fifo_queue: errors");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_unique_fifo_queue: errors");
    $finish;
  end

endmodule
